// ===== rtl/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg: shared constants for the triangle circumcenter block
// Multiplier limb width and multiplier pipeline depth.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

    // width of one unsigned partial-product limb
    localparam int LIMB_BITS = 32;

    // register stages inside one multiplier, input to product
    localparam int MUL_LAT = 4;

endpackage

`default_nettype wire

// ===== rtl/tce_mul.sv =====
// ----------------------------------------------------------------------------
// tce_mul: pipelined signed multiplier
// Sign-magnitude multiply split into 32x32 limb products, four stages:
// magnitude, limb products, partial sum, sign.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_mul #(
    parameter int AW = 8,
    parameter int BW = 8
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int LW  = tce_pkg::LIMB_BITS;
    localparam int NA  = (AW + LW - 1) / LW;
    localparam int NB  = (BW + LW - 1) / LW;
    localparam int PW  = AW + BW;
    localparam int ACW = (NA + NB) * LW;

    logic [AW-1:0]      a_mag;
    logic [BW-1:0]      b_mag;
    logic [NA*LW-1:0]   ma_reg;
    logic [NB*LW-1:0]   mb_reg;
    logic               sg_a_reg;
    logic               sg_b_reg;
    logic               sg_c_reg;
    logic [2*LW-1:0]    pp_reg [NA][NB];
    logic [ACW-1:0]     acc;
    logic [PW-1:0]      sum_reg;
    logic signed [PW-1:0] p_reg;

    // take magnitudes of both operands
    always_comb begin
        a_mag = a[AW-1] ? (~$unsigned(a) + AW'(1)) : $unsigned(a);
        b_mag = b[BW-1] ? (~$unsigned(b) + BW'(1)) : $unsigned(b);
    end

    // add up the shifted limb products
    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (ACW'(pp_reg[i][j]) << ((i + j) * LW));
            end
        end
    end

    // advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= (NA*LW)'(a_mag);
            mb_reg   <= (NB*LW)'(b_mag);
            sg_a_reg <= a[AW-1] ^ b[BW-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= ma_reg[i*LW +: LW] * mb_reg[j*LW +: LW];
                end
            end
            sg_b_reg <= sg_a_reg;
            sum_reg  <= acc[PW-1:0];
            sg_c_reg <= sg_b_reg;
            p_reg    <= $signed(sg_c_reg ? (~sum_reg + PW'(1)) : sum_reg);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/triangle_circumcenter_encroach.sv =====
// Throughput: one triangle per cycle without back-pressure on the result side; set by the
// fully pipelined multipliers and one restoring-divider stage per quotient bit.
// Back-pressure on the result side holds the whole pipeline in place.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// triangle_circumcenter_encroach: 3D triangle circumcenter and side encroachment
// Exact wide-integer circumcenter with floor division and saturation, plus a
// diametral-sphere test for each side and a degenerate-triangle flag.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcenter_encroach #(
    parameter int COORD_BITS = 24,
    localparam int IW = ((9 * COORD_BITS + 7) / 8) * 8,
    localparam int OW = ((3 * COORD_BITS + 3 + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest first)
    input  logic [IW-1:0] s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // center_x, center_y, center_z, encroach_mask (lowest first)
    output logic [OW-1:0] m_tdata,
    // degenerate
    output logic [0:0]    m_tuser
);

    localparam int CB = COORD_BITS;
    localparam int E  = CB + 1;          // edge component
    localparam int PD = 2 * E;           // edge product
    localparam int DW = PD + 2;          // dot product
    localparam int CP = 2 * DW;          // dot-by-dot product
    localparam int CW = CP + 2;          // weight sum
    localparam int WW = CP + 1;          // corner weight
    localparam int NP = E + WW;          // edge-by-weight product
    localparam int UW = NP + 3;          // numerator
    localparam int DN = CW + 2;          // divisor
    localparam int RW = UW + 1;          // divider remainder

    localparam int S_IN    = 1;
    localparam int S_EDGE  = 2;
    localparam int S_DOT   = S_EDGE + tce_pkg::MUL_LAT + 1;
    localparam int S_CS    = S_DOT + tce_pkg::MUL_LAT + 1;
    localparam int S_NUM   = S_CS + tce_pkg::MUL_LAT + 1;
    localparam int S_PREP  = S_NUM + 1;
    localparam int S_DIV0  = S_PREP + 1;
    localparam int S_DLAST = S_PREP + CB;
    localparam int NST     = S_DLAST + 1;

    localparam logic signed [CB+1:0] CEN_HI = (CB+2)'((longint'(1) << (CB - 1)) - 1);
    localparam logic signed [CB+1:0] CEN_LO = -CEN_HI - (CB+2)'(1);

    // edge index: 0 e01, 1 e02, 2 e10, 3 e12, 4 e20, 5 e21
    localparam int M1A [6] = '{1, 3, 4, 0, 3, 4};
    localparam int M1B [6] = '{0, 2, 5, 0, 3, 4};
    // dot index: 0 d0, 1 d1, 2 d2, 3 l01, 4 l12, 5 l20
    localparam int M2A [9] = '{1, 2, 0, 0, 1, 2, 5, 3, 3};
    localparam int M2B [9] = '{2, 0, 1, 0, 1, 2, 4, 5, 4};

    logic                 en;
    logic                 vld_reg [1:NST];

    logic signed [CB-1:0] pin_reg [9];
    logic signed [E-1:0]  e_reg [6][3];
    logic signed [CB-1:0] a_pipe_reg [S_EDGE:S_DLAST][3];
    logic signed [E-1:0]  ep_reg [S_EDGE+1:S_CS][2][3];

    logic signed [E-1:0]  m1a [18];
    logic signed [E-1:0]  m1b [18];
    logic signed [PD-1:0] m1p [18];
    logic signed [DW-1:0] dot_reg [6];
    logic signed [CP-1:0] m2p [9];

    logic signed [CW-1:0] cs_pipe_reg [S_CS:S_NUM-1];
    logic signed [WW-1:0] wa_reg;
    logic signed [WW-1:0] wb_reg;
    logic signed [CP+1:0] side_diff [3];
    logic [2:0]           mask_next;
    logic [2:0]           mask_pipe_reg [S_CS:S_DLAST];
    logic signed [NP-1:0] m3p [6];

    logic signed [UW-1:0] num_reg [3];
    logic [DN-1:0]        dv_reg [S_NUM:S_DLAST];
    logic                 deg_pipe_reg [S_NUM:S_DLAST];
    logic [RW-1:0]        r_reg [S_PREP:S_DLAST][3];
    logic [CB-1:0]        q_reg [S_PREP:S_DLAST][3];
    logic                 neg_reg [S_PREP:S_DLAST][3];
    logic                 ovf_reg [S_PREP:S_DLAST][3];

    logic signed [CB-1:0] cen_next [3];
    logic signed [CB-1:0] cen_reg [3];
    logic [2:0]           mask_out_reg;
    logic                 deg_out_reg;

    // advance whenever the result register is free or being taken
    assign en       = !vld_reg[NST] || m_tready;
    assign s_tready = en;

    // shift the stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= NST; s++) vld_reg[s] <= 1'b0;
        end else if (en) begin
            vld_reg[1] <= s_tvalid;
            for (int s = 2; s <= NST; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    // capture corners, form edges, carry the first corner and the edges e01 and e02
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) pin_reg[i] <= $signed(s_tdata[i*CB +: CB]);
            for (int k = 0; k < 3; k++) begin
                e_reg[0][k] <= E'(pin_reg[3+k]) - E'(pin_reg[k]);
                e_reg[1][k] <= E'(pin_reg[6+k]) - E'(pin_reg[k]);
                e_reg[2][k] <= E'(pin_reg[k])   - E'(pin_reg[3+k]);
                e_reg[3][k] <= E'(pin_reg[6+k]) - E'(pin_reg[3+k]);
                e_reg[4][k] <= E'(pin_reg[k])   - E'(pin_reg[6+k]);
                e_reg[5][k] <= E'(pin_reg[3+k]) - E'(pin_reg[6+k]);
                a_pipe_reg[S_EDGE][k] <= pin_reg[k];
                ep_reg[S_EDGE+1][0][k] <= e_reg[0][k];
                ep_reg[S_EDGE+1][1][k] <= e_reg[1][k];
            end
            for (int s = S_EDGE + 1; s <= S_DLAST; s++) a_pipe_reg[s] <= a_pipe_reg[s-1];
            for (int s = S_EDGE + 2; s <= S_CS; s++) ep_reg[s] <= ep_reg[s-1];
        end
    end

    // edge products for the corner dots and side lengths
    for (genvar g = 0; g < 18; g++) begin : g_mul1
        assign m1a[g] = e_reg[M1A[g/3]][g%3];
        assign m1b[g] = e_reg[M1B[g/3]][g%3];
        tce_mul #(.AW(E), .BW(E)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (m1a[g]),
            .b    (m1b[g]),
            .p    (m1p[g])
        );
    end

    // sum the three components of each dot
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int d = 0; d < 6; d++) begin
                dot_reg[d] <= DW'(m1p[3*d]) + DW'(m1p[3*d+1]) + DW'(m1p[3*d+2]);
            end
        end
    end

    // corner weights, squared dots and side-length products
    for (genvar g = 0; g < 9; g++) begin : g_mul2
        tce_mul #(.AW(DW), .BW(DW)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (dot_reg[M2A[g]]),
            .b    (dot_reg[M2B[g]]),
            .p    (m2p[g])
        );
    end

    // side encroached when twice the squared dot does not exceed the lengths
    always_comb begin
        side_diff[0] = (CP+2)'(m2p[6]) - ((CP+2)'(m2p[5]) <<< 1);
        side_diff[1] = (CP+2)'(m2p[7]) - ((CP+2)'(m2p[3]) <<< 1);
        side_diff[2] = (CP+2)'(m2p[8]) - ((CP+2)'(m2p[4]) <<< 1);
        for (int k = 0; k < 3; k++) mask_next[k] = !side_diff[k][CP+1];
    end

    // total weight and barycentric weight pairs
    always_ff @(posedge aclk) begin
        if (en) begin
            cs_pipe_reg[S_CS] <= CW'(m2p[0]) + CW'(m2p[1]) + CW'(m2p[2]);
            wa_reg <= WW'(m2p[2]) + WW'(m2p[0]);
            wb_reg <= WW'(m2p[0]) + WW'(m2p[1]);
            mask_pipe_reg[S_CS] <= mask_next;
            for (int s = S_CS + 1; s <= S_NUM - 1; s++) cs_pipe_reg[s] <= cs_pipe_reg[s-1];
            for (int s = S_CS + 1; s <= S_DLAST; s++) mask_pipe_reg[s] <= mask_pipe_reg[s-1];
        end
    end

    // edge components times weights
    for (genvar g = 0; g < 6; g++) begin : g_mul3
        tce_mul #(.AW(E), .BW(WW)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (ep_reg[S_CS][g/3][g%3]),
            .b    ((g < 3) ? wa_reg : wb_reg),
            .p    (m3p[g])
        );
    end

    // numerator with rounding offset, divisor, degenerate flag
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= ((UW'(m3p[k]) + UW'(m3p[3+k])) <<< 1)
                              + (UW'(cs_pipe_reg[S_NUM-1]) <<< 1);
            end
            dv_reg[S_NUM]       <= DN'($unsigned(cs_pipe_reg[S_NUM-1])) << 2;
            deg_pipe_reg[S_NUM] <= (cs_pipe_reg[S_NUM-1] == '0);
            for (int s = S_NUM + 1; s <= S_DLAST; s++) begin
                dv_reg[s]       <= dv_reg[s-1];
                deg_pipe_reg[s] <= deg_pipe_reg[s-1];
            end
        end
    end

    // fold sign into the dividend and run one quotient bit per stage
    always_ff @(posedge aclk) begin
        logic signed [RW-1:0] nx;
        logic [RW-1:0]        np;
        logic [RW-1:0]        dsh;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                nx = RW'(num_reg[k]);
                np = nx[RW-1] ? ($unsigned(-nx) + RW'(dv_reg[S_PREP-1]) - RW'(1))
                              : $unsigned(nx);
                r_reg[S_PREP][k]   <= np;
                q_reg[S_PREP][k]   <= '0;
                neg_reg[S_PREP][k] <= nx[RW-1];
                ovf_reg[S_PREP][k] <= (np >= (RW'(dv_reg[S_PREP-1]) << CB));
            end
            for (int s = S_DIV0; s <= S_DLAST; s++) begin
                for (int k = 0; k < 3; k++) begin
                    dsh = RW'(dv_reg[s-1]) << (S_DLAST - s);
                    if (r_reg[s-1][k] >= dsh) begin
                        r_reg[s][k] <= r_reg[s-1][k] - dsh;
                        q_reg[s][k] <= q_reg[s-1][k] | (CB'(1) << (S_DLAST - s));
                    end else begin
                        r_reg[s][k] <= r_reg[s-1][k];
                        q_reg[s][k] <= q_reg[s-1][k];
                    end
                    neg_reg[s][k] <= neg_reg[s-1][k];
                    ovf_reg[s][k] <= ovf_reg[s-1][k];
                end
            end
        end
    end

    // add the quotient to the first corner and saturate; zero for a degenerate triangle
    always_comb begin
        logic signed [CB:0]   qs;
        logic signed [CB+1:0] cen;
        for (int k = 0; k < 3; k++) begin
            qs  = $signed({1'b0, q_reg[S_DLAST][k]});
            qs  = neg_reg[S_DLAST][k] ? -qs : qs;
            cen = (CB+2)'(a_pipe_reg[S_DLAST][k]) + (CB+2)'(qs);
            if (ovf_reg[S_DLAST][k]) begin
                cen_next[k] = neg_reg[S_DLAST][k] ? CEN_LO[CB-1:0] : CEN_HI[CB-1:0];
            end else if (cen > CEN_HI) begin
                cen_next[k] = CEN_HI[CB-1:0];
            end else if (cen < CEN_LO) begin
                cen_next[k] = CEN_LO[CB-1:0];
            end else begin
                cen_next[k] = cen[CB-1:0];
            end
            if (deg_pipe_reg[S_DLAST]) cen_next[k] = '0;
        end
    end

    // hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) cen_reg[k] <= cen_next[k];
            mask_out_reg <= deg_pipe_reg[S_DLAST] ? 3'b000 : mask_pipe_reg[S_DLAST];
            deg_out_reg  <= deg_pipe_reg[S_DLAST];
        end
    end

    assign m_tvalid   = vld_reg[NST];
    assign m_tdata    = OW'({mask_out_reg, cen_reg[2], cen_reg[1], cen_reg[0]});
    assign m_tuser[0] = deg_out_reg;

    // degenerate result carries no center and no mask
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[3*CB+2:0] == '0)
        else $error("degenerate beat with nonzero payload");

    // a stalled result freezes the input, last divider and output stage valid bits
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NST] && !m_tready |=> $stable(vld_reg[1]) && $stable(vld_reg[S_DLAST])
                                      && $stable(vld_reg[NST]))
        else $error("pipeline moved during stall");

    // x-channel divider remainder ends below the divisor when no overflow
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_DLAST] && !ovf_reg[S_DLAST][0]
        |-> r_reg[S_DLAST][0] < RW'(dv_reg[S_DLAST]))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

// ===== dv/tb_triangle_circumcenter_encroach.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_circumcenter_encroach: self-checking bench for the circumcenter block
// Streams directed and random triangles through the block with random idling
// on both sides and checks every result beat against an exact wide-integer
// circumcenter, encroachment and degeneracy calculation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_circumcenter_encroach;

    localparam int CB        = 24;
    localparam int IW        = 216;
    localparam int OW        = 80;
    localparam int N_RANDOM  = 500;
    localparam int DRAIN     = 60;
    localparam int MAX_CYCLE = 400000;

    typedef logic signed [191:0] wint_t;

    typedef struct packed {
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB-1:0] cz;
        logic [2:0]    mask;
        logic          degen;
    } circ_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [IW-1:0] s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [OW-1:0] m_tdata;
    logic [0:0]    m_tuser;

    logic [IW-1:0] tri_q[$];
    circ_t         circ_q[$];
    int            n_total;
    int            n_sent;
    int            n_err;
    int            n_cycle;

    triangle_circumcenter_encroach #(.COORD_BITS(CB)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // append one triangle to the pending queue
    task automatic queue_tri(input logic [IW-1:0] t);
        tri_q.insert(tri_q.size(), t);
    endtask

    // floor division for a positive divisor
    function automatic wint_t floor_div(wint_t n, wint_t d);
        wint_t q;
        q = n / d;
        if (n < 0 && q * d != n) q = q - 1;
        return q;
    endfunction

    // exact circumcenter, side encroachment and degeneracy of one triangle
    function automatic circ_t circumcenter(logic [IW-1:0] t);
        wint_t p[3][3];
        wint_t e01[3], e02[3], e12[3], e20[3];
        wint_t d0, d1, d2, c0, c1, c2, cs, den, den2, wa, wb, nrel, num, cen;
        wint_t hi, lo, l01, l12, l20;
        logic [CB-1:0] res[3];
        circ_t r;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                p[i][k] = $signed(t[(i*3+k)*CB +: CB]);
        for (int k = 0; k < 3; k++) begin
            e01[k] = p[1][k] - p[0][k];
            e02[k] = p[2][k] - p[0][k];
            e12[k] = p[2][k] - p[1][k];
            e20[k] = p[0][k] - p[2][k];
        end
        d0 = e02[0]*e01[0] + e02[1]*e01[1] + e02[2]*e01[2];
        d1 = -(e12[0]*e01[0] + e12[1]*e01[1] + e12[2]*e01[2]);
        d2 = e20[0]*e12[0] + e20[1]*e12[1] + e20[2]*e12[2];
        d2 = -d2;
        c0 = d1 * d2;
        c1 = d2 * d0;
        c2 = d0 * d1;
        cs = c0 + c1 + c2;
        r = '0;
        if (cs == 0) begin
            r.degen = 1'b1;
            return r;
        end
        den  = cs + cs;
        den2 = den + den;
        wa   = c2 + c0;
        wb   = c0 + c1;
        hi   = (192'sd1 <<< (CB - 1)) - 1;
        lo   = -hi - 1;
        for (int k = 0; k < 3; k++) begin
            nrel = e01[k] * wa + e02[k] * wb;
            num  = nrel + nrel + den;
            cen  = p[0][k] + floor_div(num, den2);
            // clamp to the coordinate range
            if (cen > hi) cen = hi;
            else if (cen < lo) cen = lo;
            res[k] = cen[CB-1:0];
        end
        r.cx = res[0];
        r.cy = res[1];
        r.cz = res[2];
        l01 = e01[0]*e01[0] + e01[1]*e01[1] + e01[2]*e01[2];
        l12 = e12[0]*e12[0] + e12[1]*e12[1] + e12[2]*e12[2];
        l20 = e20[0]*e20[0] + e20[1]*e20[1] + e20[2]*e20[2];
        r.mask[0] = (l20 * l12 - 2 * d2 * d2) >= 0;
        r.mask[1] = (l01 * l20 - 2 * d0 * d0) >= 0;
        r.mask[2] = (l01 * l12 - 2 * d1 * d1) >= 0;
        return r;
    endfunction

    function automatic logic [IW-1:0] pack_tri(int ax, int ay, int az, int bx, int by,
                                               int bz, int cx, int cy, int cz);
        logic [CB-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2;
        a0 = ax[CB-1:0]; a1 = ay[CB-1:0]; a2 = az[CB-1:0];
        b0 = bx[CB-1:0]; b1 = by[CB-1:0]; b2 = bz[CB-1:0];
        c0 = cx[CB-1:0]; c1 = cy[CB-1:0]; c2 = cz[CB-1:0];
        return {c2, c1, c0, b2, b1, b0, a2, a1, a0};
    endfunction

    // random coordinate: full range, a small box or a mid-size box
    function automatic int rand_coord(int mode);
        case (mode)
            0: return int'($signed(24'($urandom)));
            1: return $urandom_range(0, 2048) - 1024;
            default: return $urandom_range(0, 200000) - 100000;
        endcase
    endfunction

    function automatic logic [IW-1:0] rand_tri();
        int m, v[9], s, t;
        m = $urandom_range(0, 9);
        if (m < 4) begin
            for (int i = 0; i < 9; i++) v[i] = rand_coord(0);
        end else if (m < 6) begin
            for (int i = 0; i < 9; i++) v[i] = rand_coord(1);
        end else if (m < 8) begin
            for (int i = 0; i < 9; i++) v[i] = rand_coord(2);
        end else begin
            // nearly or exactly collinear: c on the line through a and b
            for (int i = 0; i < 6; i++) v[i] = rand_coord(1) * 64;
            s = $urandom_range(0, 4) - 2;
            for (int k = 0; k < 3; k++) begin
                t = $urandom_range(0, 2) - 1;
                v[6+k] = v[k] + s * (v[3+k] - v[k]) + ((m == 9) ? t : 0);
            end
        end
        return pack_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    endfunction

    // idle ratios per third of the run: sender, then receiver
    function automatic bit idle_now(bit sender);
        int ph;
        ph = (n_sent * 3) / n_total;
        if (ph == 0) return ($urandom_range(0, 99) < (sender ? 26 : 45));
        if (ph == 1) return ($urandom_range(0, 99) < (sender ? 45 : 26));
        return 1'b0;
    endfunction

    // driver: present the queue front, advance on each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            s_tvalid <= 1'b1;
        end else begin
            if (s_tvalid) begin
                circ_q.insert(circ_q.size(), circumcenter(tri_q[0]));
                void'(tri_q.pop_front());
                n_sent++;
            end
            if (tri_q.size() > 0 && !idle_now(1'b1)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= tri_q[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each result beat against the oldest expected center
    always @(posedge aclk) begin
        circ_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_now(1'b0);
            if (m_tvalid && m_tready) begin
                got.cx    = m_tdata[CB-1:0];
                got.cy    = m_tdata[2*CB-1:CB];
                got.cz    = m_tdata[3*CB-1:2*CB];
                got.mask  = m_tdata[3*CB+2:3*CB];
                got.degen = m_tuser[0];
                if (circ_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result beat %h", got);
                end else begin
                    want = circ_q.pop_front();
                    if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz ||
                        got.mask !== want.mask || got.degen !== want.degen) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"mismatch: exp c=(%h %h %h) m=%b d=%b",
                                      " got c=(%h %h %h) m=%b d=%b"},
                                     want.cx, want.cy, want.cz, want.mask, want.degen,
                                     got.cx, got.cy, got.cz, got.mask, got.degen);
                    end
                end
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        n_cycle++;
        if (n_cycle > MAX_CYCLE) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int mx, mn;
        mx = 8388607;
        mn = -8388608;
        n_err    = 0;
        n_sent   = 0;
        n_cycle  = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        // directed triangles
        queue_tri(pack_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tri(pack_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        queue_tri(pack_tri(mn, mn, mn, mx, mx, mx, 0, 0, 0));
        queue_tri(pack_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn));
        queue_tri(pack_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx));
        queue_tri(pack_tri(mn, 0, 0, 0, mx, 0, 0, 0, mn));
        queue_tri(pack_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
        queue_tri(pack_tri(0, 0, 0, 256, 0, 0, 128, 222, 0));
        queue_tri(pack_tri(0, 0, 0, 1024, 0, 0, 512, 10, 0));
        queue_tri(pack_tri(0, 0, 0, 1024, 0, 0, 512, 512, 0));
        queue_tri(pack_tri(mn, 0, 0, mx, 1, 0, 0, 0, 0));
        queue_tri(pack_tri(mn, mn, 0, mx, mx, 0, 0, 1, 0));
        queue_tri(pack_tri(mn, mx, 5, mx, mn, 5, 1, 0, 5));
        queue_tri(pack_tri(10, 20, 30, 10, 20, 30, 99, 5, 7));
        queue_tri(pack_tri(0, 0, 0, 100, 100, 100, 300, 300, 300));
        queue_tri(pack_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));
        queue_tri(pack_tri(-1, -1, -1, mn, mx, 0, mx, 0, mn));
        queue_tri(pack_tri(0, 0, 0, 0, 0, 512, 0, 512, 0));
        queue_tri(pack_tri(mx, 0, 0, mx, 1, 0, mx, 0, 1));
        queue_tri(pack_tri(0, 0, 0, 1, 0, 0, -1, 0, 0));
        for (int i = 0; i < N_RANDOM; i++) queue_tri(rand_tri());
        n_total = tri_q.size();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // drain: all beats sent, all results back, then let the pipe settle
        while (tri_q.size() > 0 || circ_q.size() > 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/tce_pkg.sv
rtl/tce_mul.sv
rtl/triangle_circumcenter_encroach.sv
dv/tb_triangle_circumcenter_encroach.sv
